### rtl/core/sacn_pkg.sv
// Shared constants and helpers for the sACN data packet parser.
package sacn_pkg;

  // Default configuration
  localparam int UNIVERSE_COUNT_DEFAULT = 24;
  localparam int MAX_SLOTS_DEFAULT      = 512;

  // Field widths
  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 16;
  localparam int UNIV_W  = 5;
  localparam int SLOT_W  = 9;
  localparam int COUNT_W = 10;

  // Byte positions within the datagram
  localparam logic [LEN_W-1:0] POS_ROOT_END = 16'd22;
  localparam logic [LEN_W-1:0] POS_CID_LO   = 16'd16;
  localparam logic [LEN_W-1:0] POS_CID_HI   = 16'd17;
  localparam logic [LEN_W-1:0] POS_FVEC_0   = 16'd40;
  localparam logic [LEN_W-1:0] POS_FVEC_2   = 16'd42;
  localparam logic [LEN_W-1:0] POS_FVEC_3   = 16'd43;
  localparam logic [LEN_W-1:0] POS_UNIV_HI  = 16'd113;
  localparam logic [LEN_W-1:0] POS_UNIV_LO  = 16'd114;
  localparam logic [LEN_W-1:0] POS_CNT_HI   = 16'd123;
  localparam logic [LEN_W-1:0] POS_CNT_LO   = 16'd124;
  localparam logic [LEN_W-1:0] POS_DATA     = 16'd126;
  localparam logic [LEN_W-1:0] MIN_LENGTH   = 16'd128;

  localparam logic [BYTE_W-1:0] FRAMING_VECTOR_LSB = 8'h02;

  // Expected root layer bytes: preamble, postamble, identifier, root vector
  function automatic logic [BYTE_W-1:0] root_expect(input logic [4:0] idx);
    logic [BYTE_W-1:0] e;
    case (idx)
      5'd1:    e = 8'h10;
      5'd4:    e = 8'h41; // A
      5'd5:    e = 8'h53; // S
      5'd6:    e = 8'h43; // C
      5'd7:    e = 8'h2d; // -
      5'd8:    e = 8'h45; // E
      5'd9:    e = 8'h31; // 1
      5'd10:   e = 8'h2e; // .
      5'd11:   e = 8'h31; // 1
      5'd12:   e = 8'h37; // 7
      5'd21:   e = 8'h04;
      default: e = 8'h00;
    endcase
    return e;
  endfunction

  // True when a byte at a position matches the required format
  function automatic logic byte_ok(input logic [LEN_W-1:0] pos,
                                   input logic [BYTE_W-1:0] b);
    logic ok;
    ok = 1'b1;
    if (pos < POS_ROOT_END) begin
      if (pos != POS_CID_LO && pos != POS_CID_HI) begin
        ok = (b == root_expect(pos[4:0]));
      end
    end else if (pos >= POS_FVEC_0 && pos <= POS_FVEC_2) begin
      ok = (b == '0);
    end else if (pos == POS_FVEC_3) begin
      ok = (b == FRAMING_VECTOR_LSB);
    end
    return ok;
  endfunction

endpackage

### rtl/core/sacn_dmx_packet_parser_top.sv
// sACN data packet parser: byte stream in, DMX slot words out.
//
// Takes one UDP payload byte per cycle while in_stall is low, first_byte
// marking a datagram start and packet_length sampled on it. The ACN root layer
// and framing vector are checked as bytes pass; for a datagram of at least
// 128 bytes whose universe (minus one) is below UNIVERSE_COUNT, each DMX
// slot byte from position 126 up to the property count (capped at
// MAX_SLOTS) and the datagram end yields one output word, last_slot set on
// the final one. One byte is accepted per cycle while in_stall is low; its
// word, if any, is registered into the output register, or into a
// one-word skid register while the output is stalled, so input continues;
// in_stall rises only when both are full.
module sacn_dmx_packet_parser_top #(
  parameter int UNIVERSE_COUNT = sacn_pkg::UNIVERSE_COUNT_DEFAULT,
  parameter int MAX_SLOTS      = sacn_pkg::MAX_SLOTS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [sacn_pkg::BYTE_W-1:0]  data_byte,
  input  logic                         first_byte,
  input  logic [sacn_pkg::LEN_W-1:0]   packet_length,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [sacn_pkg::UNIV_W-1:0]  universe_index,
  output logic [sacn_pkg::SLOT_W-1:0]  slot_index,
  output logic [sacn_pkg::BYTE_W-1:0]  slot_value,
  output logic                         last_slot
);

  typedef struct packed {
    logic [sacn_pkg::UNIV_W-1:0] universe;
    logic [sacn_pkg::SLOT_W-1:0] slot;
    logic [sacn_pkg::BYTE_W-1:0] value;
    logic                        last;
  } slot_word_t;

  localparam logic [sacn_pkg::COUNT_W-1:0] SLOT_CAP = sacn_pkg::COUNT_W'(MAX_SLOTS);
  localparam logic [sacn_pkg::LEN_W-1:0]   UNIV_LIMIT = sacn_pkg::LEN_W'(UNIVERSE_COUNT);

  // Parser state
  logic [sacn_pkg::LEN_W-1:0]   byte_position, byte_position_next;
  logic                         packet_still_valid, packet_still_valid_next;
  logic [sacn_pkg::LEN_W-1:0]   length_latched, length_latched_next;
  logic [sacn_pkg::BYTE_W-1:0]  high_byte_latch, high_byte_latch_next;
  logic [sacn_pkg::LEN_W-1:0]   universe_latched, universe_latched_next;
  logic [sacn_pkg::COUNT_W-1:0] slot_count, slot_count_next;

  // Output register and skid register
  slot_word_t out_word;
  slot_word_t skid_word;
  logic       skid_valid;

  logic       in_take;
  logic       out_take;
  logic       res_valid;
  slot_word_t res_word;

  assign in_stall = skid_valid;
  assign in_take  = in_valid && !skid_valid;
  assign out_take = out_valid && !out_stall;

  // Per-byte parse step
  always_comb begin
    logic [sacn_pkg::LEN_W-1:0]   pos;
    logic [sacn_pkg::LEN_W-1:0]   len;
    logic                         ok;
    logic [sacn_pkg::BYTE_W-1:0]  hi;
    logic [sacn_pkg::LEN_W-1:0]   univ;
    logic [sacn_pkg::COUNT_W-1:0] cnt;
    logic [sacn_pkg::LEN_W-1:0]   v;
    logic [sacn_pkg::LEN_W-1:0]   k;

    if (first_byte) begin
      pos  = '0;
      len  = packet_length;
      ok   = (packet_length >= sacn_pkg::MIN_LENGTH);
      hi   = '0;
      univ = '0;
      cnt  = '0;
    end else begin
      pos  = byte_position;
      len  = length_latched;
      ok   = packet_still_valid;
      hi   = high_byte_latch;
      univ = universe_latched;
      cnt  = slot_count;
    end

    v = {hi, data_byte};
    k = pos - sacn_pkg::POS_DATA;

    byte_position_next      = pos;
    packet_still_valid_next = ok;
    length_latched_next     = len;
    high_byte_latch_next    = hi;
    universe_latched_next   = univ;
    slot_count_next         = cnt;
    res_valid               = 1'b0;
    res_word.universe       = univ[sacn_pkg::UNIV_W-1:0];
    res_word.slot           = k[sacn_pkg::SLOT_W-1:0];
    res_word.value          = data_byte;
    res_word.last           = (k + 16'd1 == {6'd0, cnt}) || (pos + 16'd1 == len);

    if (pos >= len) begin
      // past the datagram end: drop and hold position
      packet_still_valid_next = 1'b0;
    end else begin
      byte_position_next = pos + 16'd1;
      if (ok) begin
        if (!sacn_pkg::byte_ok(pos, data_byte)) begin
          packet_still_valid_next = 1'b0;
        end else if (pos == sacn_pkg::POS_UNIV_HI || pos == sacn_pkg::POS_CNT_HI) begin
          high_byte_latch_next = data_byte;
        end else if (pos == sacn_pkg::POS_UNIV_LO) begin
          universe_latched_next = (v != '0) ? v - 16'd1 : v;
        end else if (pos == sacn_pkg::POS_CNT_LO) begin
          slot_count_next = (v > {6'd0, SLOT_CAP}) ? SLOT_CAP
                                                  : v[sacn_pkg::COUNT_W-1:0];
        end else if (pos >= sacn_pkg::POS_DATA) begin
          res_valid = (k < {6'd0, cnt}) && (univ < UNIV_LIMIT);
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position      <= '0;
      packet_still_valid <= 1'b0;
      length_latched     <= '0;
      high_byte_latch    <= '0;
      universe_latched   <= '0;
      slot_count         <= '0;
    end else if (in_take) begin
      byte_position      <= byte_position_next;
      packet_still_valid <= packet_still_valid_next;
      length_latched     <= length_latched_next;
      high_byte_latch    <= high_byte_latch_next;
      universe_latched   <= universe_latched_next;
      slot_count         <= slot_count_next;
    end
  end

  // Output and skid control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        skid_valid <= 1'b0;
      end
    end else if (in_take && res_valid) begin
      if (out_valid && !out_take) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  // Output and skid payload
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        out_word <= skid_word;
      end
    end else if (in_take && res_valid) begin
      if (out_valid && !out_take) begin
        skid_word <= res_word;
      end else begin
        out_word <= res_word;
      end
    end
  end

  assign universe_index = out_word.universe;
  assign slot_index     = out_word.slot;
  assign slot_value     = out_word.value;
  assign last_slot      = out_word.last;

  // Checks
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid word held while output register empty");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !out_stall) |=> (out_valid && !skid_valid))
    else $error("skid word not moved to output register");

  a_valid_length: assert property (@(posedge clk) disable iff (rst)
    packet_still_valid |-> (length_latched >= sacn_pkg::MIN_LENGTH))
    else $error("short datagram marked valid");

  a_count_capped: assert property (@(posedge clk) disable iff (rst)
    slot_count <= SLOT_CAP)
    else $error("slot count above cap");

  a_universe_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((UNIVERSE_COUNT > 32) || (int'(universe_index) < UNIVERSE_COUNT)))
    else $error("word for universe out of range");

endmodule

### tb/sacn_dmx_packet_parser_checker.sv
// Checker: predicts the parser's slot writes from accepted bytes and compares them.
module sacn_dmx_packet_parser_checker #(
  parameter int UNIVERSE_COUNT = sacn_pkg::UNIVERSE_COUNT_DEFAULT,
  parameter int MAX_SLOTS      = sacn_pkg::MAX_SLOTS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [sacn_pkg::BYTE_W-1:0] data_byte,
  input  logic                        first_byte,
  input  logic [sacn_pkg::LEN_W-1:0]  packet_length,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [sacn_pkg::UNIV_W-1:0] universe_index,
  input  logic [sacn_pkg::SLOT_W-1:0] slot_index,
  input  logic [sacn_pkg::BYTE_W-1:0] slot_value,
  input  logic                        last_slot,
  output int                          fail_count,
  output int                          pending_count,
  output int                          checked_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // Datagram layout
  localparam logic [71:0] ACN_IDENT    = "ASC-E1.17";
  localparam logic [7:0]  PREAMBLE_LSB = 8'h10;
  localparam logic [7:0]  ROOT_VECTOR  = 8'h04;
  localparam logic [7:0]  FRAMING_CODE = 8'h02;
  localparam int ROOT_BYTES   = 22;
  localparam int CID_FIRST    = 16;
  localparam int CID_LAST     = 17;
  localparam int FVEC_FIRST   = 40;
  localparam int FVEC_LAST    = 43;
  localparam int UNIV_MSB_AT  = 113;
  localparam int UNIV_LSB_AT  = 114;
  localparam int COUNT_MSB_AT = 123;
  localparam int COUNT_LSB_AT = 124;
  localparam int SLOTS_AT     = 126;
  localparam int MIN_FRAME    = 128;

  typedef struct packed {
    logic [sacn_pkg::UNIV_W-1:0] universe;
    logic [sacn_pkg::SLOT_W-1:0] slot;
    logic [sacn_pkg::BYTE_W-1:0] level;
    logic                        last;
  } slot_write_t;

  slot_write_t slot_writes[$];

  // Parser state as predicted
  logic [15:0] next_pos;
  logic [15:0] frame_len;
  logic        frame_ok;
  logic [7:0]  msb_hold;
  logic [15:0] univ_word;
  logic [9:0]  slot_limit;
  int          errors = 0;

  // Required value of a root layer byte
  function automatic logic [7:0] root_byte(input int i);
    if (i == 1) return PREAMBLE_LSB;
    if (i >= 4 && i <= 12) return ACN_IDENT[8*(12-i) +: 8];
    if (i == ROOT_BYTES - 1) return ROOT_VECTOR;
    return 8'h00;
  endfunction

  // Header bytes that must match; everything else passes
  function automatic logic header_ok(input int p, input logic [7:0] b);
    if (p < ROOT_BYTES) return (p == CID_FIRST || p == CID_LAST) || (b == root_byte(p));
    if (p >= FVEC_FIRST && p < FVEC_LAST) return b == 8'h00;
    if (p == FVEC_LAST) return b == FRAMING_CODE;
    return 1'b1;
  endfunction

  task automatic predict_byte(input logic [7:0] b, input logic f, input logic [15:0] l);
    int          p;
    int          k;
    logic [15:0] w;
    slot_write_t wr;
    if (f) begin
      next_pos   = '0;
      frame_len  = l;
      frame_ok   = (l >= MIN_FRAME);
      msb_hold   = '0;
      univ_word  = '0;
      slot_limit = '0;
    end
    p = next_pos;
    if (p >= frame_len) begin
      // past the datagram end: dropped, position holds
      frame_ok = 1'b0;
    end else begin
      next_pos = next_pos + 16'd1;
      if (frame_ok && !header_ok(p, b)) begin
        frame_ok = 1'b0;
      end else if (frame_ok) begin
        if (p == UNIV_MSB_AT || p == COUNT_MSB_AT) begin
          msb_hold = b;
        end else if (p == UNIV_LSB_AT) begin
          w = {msb_hold, b};
          univ_word = (w == 16'd0) ? w : w - 16'd1;
        end else if (p == COUNT_LSB_AT) begin
          w = {msb_hold, b};
          slot_limit = (w > MAX_SLOTS) ? 10'(MAX_SLOTS) : w[9:0];
        end else if (p >= SLOTS_AT) begin
          k = p - SLOTS_AT;
          if (k < slot_limit && univ_word < UNIVERSE_COUNT) begin
            wr.universe = univ_word[sacn_pkg::UNIV_W-1:0];
            wr.slot     = k[sacn_pkg::SLOT_W-1:0];
            wr.level    = b;
            wr.last     = (k + 1 == slot_limit) || (p + 1 == frame_len);
            slot_writes.push_back(wr);
          end
        end
      end
    end
  endtask

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0d ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      errors++;
    end
  endtask

  // Compare outgoing words first, then predict from the incoming byte
  always @(posedge clk) begin
    slot_write_t want;
    if (rst) begin
      slot_writes.delete();
      next_pos      = '0;
      frame_len     = '0;
      frame_ok      = 1'b0;
      msb_hold      = '0;
      univ_word     = '0;
      slot_limit    = '0;
      checked_count <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (slot_writes.size() == 0) begin
          $display("%0d ns: unexpected word, expected none, actual universe %0d slot %0d",
                   $time, universe_index, slot_index);
          $display("%0d ns: unexpected word continued, actual value %0d last %0b",
                   $time, slot_value, last_slot);
          errors++;
        end else begin
          want = slot_writes.pop_front();
          check_field("universe_index", want.universe, universe_index);
          check_field("slot_index", want.slot, slot_index);
          check_field("slot_value", want.level, slot_value);
          check_field("last_slot", want.last, last_slot);
          checked_count <= checked_count + 1;
        end
      end
      if (in_valid && !in_stall) predict_byte(data_byte, first_byte, packet_length);
    end
    pending_count <= slot_writes.size();
    fail_count    <= errors;
  end

endmodule

### tb/sacn_dmx_packet_parser_top_tb.sv
// Testbench top: feeds sACN datagrams to the parser, stalls its output, reports the verdict.
module sacn_dmx_packet_parser_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT    = 2000;
  localparam int RANDOM_BYTES  = 200;
  localparam int SETTLE_CYCLES = 8;

  // Datagram layout used to build frames
  localparam logic [71:0] ACN_IDENT    = "ASC-E1.17";
  localparam logic [7:0]  PREAMBLE_LSB = 8'h10;
  localparam logic [7:0]  ROOT_VECTOR  = 8'h04;
  localparam logic [7:0]  FRAMING_CODE = 8'h02;
  localparam int UNIV_MSB_AT  = 113;
  localparam int UNIV_LSB_AT  = 114;
  localparam int COUNT_MSB_AT = 123;
  localparam int COUNT_LSB_AT = 124;
  localparam int SLOTS_AT     = 126;

  typedef enum int {DG_GOOD, DG_CORRUPT, DG_TRUNCATED, DG_NOISE} dgram_kind_e;
  typedef enum int {RX_OPEN, RX_LIGHT, RX_PERIODIC, RX_HEAVY} rx_mode_e;

  logic                        clk;
  logic                        rst;
  logic                        in_valid;
  logic                        in_stall;
  logic [sacn_pkg::BYTE_W-1:0] data_byte;
  logic                        first_byte;
  logic [sacn_pkg::LEN_W-1:0]  packet_length;
  logic                        out_valid;
  logic                        out_stall;
  logic [sacn_pkg::UNIV_W-1:0] universe_index;
  logic [sacn_pkg::SLOT_W-1:0] slot_index;
  logic [sacn_pkg::BYTE_W-1:0] slot_value;
  logic                        last_slot;

  int fail_count;
  int pending_count;
  int checked_count;
  int idle_cycles  = 0;
  int burst_left   = 0;
  int bytes_sent   = 0;
  int dgrams_sent  = 0;
  int random_bytes = 0;
  int corrupt_at[3] = '{1, 43, 16};

  sacn_dmx_packet_parser_top i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_byte      (data_byte),
    .first_byte     (first_byte),
    .packet_length  (packet_length),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .universe_index (universe_index),
    .slot_index     (slot_index),
    .slot_value     (slot_value),
    .last_slot      (last_slot)
  );

  sacn_dmx_packet_parser_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_byte      (data_byte),
    .first_byte     (first_byte),
    .packet_length  (packet_length),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .universe_index (universe_index),
    .slot_index     (slot_index),
    .slot_value     (slot_value),
    .last_slot      (last_slot),
    .fail_count     (fail_count),
    .pending_count  (pending_count),
    .checked_count  (checked_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Output backpressure: a randomly chosen mode, switched at random times
  initial begin
    rx_mode_e mode;
    int       left;
    int       tick;
    out_stall = 1'b0;
    mode = RX_OPEN;
    left = 0;
    tick = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = rx_mode_e'($urandom_range(0, 3));
        left = $urandom_range(20, 150);
      end
      left--;
      tick++;
      case (mode)
        RX_OPEN:     out_stall <= 1'b0;
        RX_LIGHT:    out_stall <= ($urandom_range(0, 99) < 25);
        RX_PERIODIC: out_stall <= ((tick % 7) < 4);
        default:     out_stall <= ($urandom_range(0, 99) < 80);
      endcase
    end
  end

  // Watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0d ns: no progress for %0d cycles", $time, IDLE_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Byte i of a datagram with the given universe and property count
  function automatic logic [7:0] frame_byte(input int i, input logic [15:0] univ,
                                            input logic [15:0] count, input logic extremes);
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (i == 1) b = PREAMBLE_LSB;
    else if (i >= 4 && i <= 12) b = ACN_IDENT[8*(12-i) +: 8];
    else if (i == 21) b = ROOT_VECTOR;
    else if (i < 22 && i != 16 && i != 17) b = 8'h00;
    else if (i >= 40 && i <= 42) b = 8'h00;
    else if (i == 43) b = FRAMING_CODE;
    else if (i == UNIV_MSB_AT) b = univ[15:8];
    else if (i == UNIV_LSB_AT) b = univ[7:0];
    else if (i == COUNT_MSB_AT) b = count[15:8];
    else if (i == COUNT_LSB_AT) b = count[7:0];
    else if (i >= SLOTS_AT && extremes) b = i[0] ? 8'hFF : 8'h00;
    return b;
  endfunction

  // One byte: bursts with random gaps, held until accepted
  task automatic send_byte(input logic [7:0] d, input logic f, input logic [15:0] l);
    @(negedge clk);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? 300 : $urandom_range(1, 40);
    end
    in_valid      <= 1'b1;
    data_byte     <= d;
    first_byte    <= f;
    packet_length <= l;
    burst_left--;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // n bytes of a datagram, one optionally flipped, then bytes past its end
  task automatic send_datagram(input logic [15:0] univ, input logic [15:0] count,
                               input logic [15:0] len, input int n, input int bad,
                               input int extra, input logic extremes);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      b = frame_byte(i, univ, count, extremes);
      if (i == bad) b = b ^ 8'($urandom_range(1, 255));
      send_byte(b, i == 0, (i == 0) ? len : 16'($urandom));
    end
    repeat (extra) send_byte(8'($urandom_range(0, 255)), 1'b0, 16'($urandom));
    dgrams_sent++;
  endtask

  initial begin
    dgram_kind_e kind;
    logic [15:0] univ;
    logic [15:0] count;
    logic [15:0] len;
    int          n;
    int          bad;
    int          extra;
    int          pick;
    rst           = 1'b1;
    in_valid      = 1'b0;
    data_byte     = '0;
    first_byte    = 1'b0;
    packet_length = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // stray bytes before any datagram start
    send_byte(8'hFF, 1'b0, 16'hFFFF);
    send_byte(8'h00, 1'b0, 16'h0000);
    send_byte(8'hA5, 1'b0, 16'h0080);

    // universes at and around the edges, last by count and by length
    send_datagram(16'd1, 16'd4, 16'd130, 130, -1, 0, 1'b1);
    send_datagram(16'd0, 16'd2, 16'd128, 128, -1, 0, 1'b0);
    send_datagram(16'd24, 16'd10, 16'd129, 129, -1, 0, 1'b1);
    send_datagram(16'd25, 16'd4, 16'd130, 130, -1, 0, 1'b0);
    // zero count, too short, zero length, cut short by the next start
    send_datagram(16'd5, 16'd0, 16'd130, 130, -1, 0, 1'b0);
    send_datagram(16'd5, 16'd4, 16'd127, 127, -1, 0, 1'b0);
    send_datagram(16'd5, 16'd4, 16'd0, 4, -1, 0, 1'b0);
    send_datagram(16'd5, 16'd20, 16'hFFFF, 135, -1, 0, 1'b0);
    // a flipped byte in the preamble and framing vector, and in an unchecked one
    foreach (corrupt_at[j]) send_datagram(16'd6, 16'd3, 16'd129, 129, corrupt_at[j], 0, 1'b0);
    // a capped count ending on the datagram length
    send_datagram(16'd2, 16'hFFFF, 16'd140, 140, -1, 1, 1'b0);

    // random datagrams, mostly well formed
    while (random_bytes < RANDOM_BYTES) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) kind = DG_GOOD;
      else if (pick == 7) kind = DG_CORRUPT;
      else if (pick == 8) kind = DG_TRUNCATED;
      else kind = DG_NOISE;
      pick = $urandom_range(0, 9);
      univ = (pick < 7) ? 16'($urandom_range(1, 24)) : (pick == 7) ? 16'd0 :
             (pick == 8) ? 16'($urandom_range(25, 40)) : 16'($urandom);
      pick = $urandom_range(0, 9);
      count = (pick < 8) ? 16'($urandom_range(1, 24)) : (pick == 8) ? 16'd0 : 16'($urandom);
      n = 126 + (($urandom_range(0, 19) == 0) ? $urandom_range(25, 200) : $urandom_range(2, 24));
      len = 16'(n);
      bad = -1;
      extra = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
      case (kind)
        DG_CORRUPT:   bad = $urandom_range(0, 43);
        DG_TRUNCATED: begin
          len = 16'($urandom_range(n + 1, 65535));
          extra = 0;
        end
        DG_NOISE: begin
          len = 16'($urandom_range(0, 127));
          n = $urandom_range(1, 30);
        end
        default: ;
      endcase
      send_datagram(univ, count, len, n, bad, extra, $urandom_range(0, 7) == 0);
      random_bytes += n;
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d datagrams, %0d bytes: in and out of range universes, capped",
             dgrams_sent, bytes_sent);
    $display("and zero counts, flipped header bytes, short and cut datagrams; %0d writes checked",
             checked_count);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
